@@ sv/tps_pkg.sv @@
`default_nettype none

package tps_pkg;

    // Table size and priority range.
    localparam int SLOT_COUNT      = 4;
    localparam int PRIORITY_LEVELS = 3;

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int PRIO_W   = $clog2(PRIORITY_LEVELS);
    localparam int ST_W     = 2;
    localparam int PRIO_MAX = PRIORITY_LEVELS - 1;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_YIELD    = 3'd1,
        CMD_EXIT     = 3'd2,
        CMD_SET_PRIO = 3'd3,
        CMD_START    = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_FULL       = 2'd1,
        STS_ALL_EXITED = 2'd2,
        STS_STARTED    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YLD_WR,
        S_EXIT_WR,
        S_SP_WR,
        S_SCAN,
        S_CREATE_WR,
        S_SCHED_WR,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic {
        MODE_CREATE,
        MODE_SCHED
    } t_scan_mode;

    // Access to the slot table: one read address and one write address per cycle.
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] wr_addr;
        logic              st_we;
        t_slot_st          st_wdata;
        logic              pr_we;
        logic [PRIO_W-1:0] pr_wdata;
    } t_tbl_req;

    // Registered read data of the slot table.
    typedef struct packed {
        t_slot_st          st;
        logic [PRIO_W-1:0] prio;
    } t_tbl_rsp;

    // One finished item from the controller.
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] cur_prio;
        logic [PRIO_W-1:0] prev_prio;
    } t_result;

    // Saturate a requested priority to the highest level.
    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [1:0] p);
        logic [PRIO_W-1:0] r;
        if (32'(p) > PRIO_MAX) begin
            r = PRIO_W'(PRIO_MAX);
        end else begin
            r = PRIO_W'(p);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/tps_ram.sv @@
`default_nettype none

module tps_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/tps_slot_table.sv @@
`default_nettype none

module tps_slot_table
    import tps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_tbl_req i_req,
    output t_tbl_rsp      o_rsp
);

    logic [SLOT_COUNT-1:0] r_st_vld;
    logic [SLOT_COUNT-1:0] r_pr_vld;
    logic                  r_st_rv;
    logic                  r_pr_rv;
    logic [ST_W-1:0]       st_q;
    logic [PRIO_W-1:0]     pr_q;

    // Slot state memory.
    tps_ram #(
        .WIDTH (ST_W),
        .DEPTH (SLOT_COUNT)
    ) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.st_we),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.st_wdata),
        .i_raddr (i_req.rd_addr),
        .o_rdata (st_q)
    );

    // Slot priority memory.
    tps_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (SLOT_COUNT)
    ) u_pr_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.pr_we),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.pr_wdata),
        .i_raddr (i_req.rd_addr),
        .o_rdata (pr_q)
    );

    // Written-entry flags; an entry never written reads as free with priority zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= '0;
            r_pr_vld <= '0;
            r_st_rv  <= 1'b0;
            r_pr_rv  <= 1'b0;
        end else begin
            if (i_req.st_we) begin
                r_st_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.pr_we) begin
                r_pr_vld[i_req.wr_addr] <= 1'b1;
            end
            r_st_rv <= r_st_vld[i_req.rd_addr];
            r_pr_rv <= r_pr_vld[i_req.rd_addr];
        end
    end

    // Mask the read data with the flag sampled alongside the read.
    always_comb begin
        o_rsp.st   = r_st_rv ? t_slot_st'(st_q) : ST_FREE;
        o_rsp.prio = r_pr_rv ? pr_q : '0;
    end

endmodule

`default_nettype wire

@@ sv/tps_ctrl.sv @@
`default_nettype none

module tps_ctrl
    import tps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_command,
    input  wire logic [1:0] i_priority_req,
    output logic            o_busy,
    output t_tbl_req        o_req,
    input  wire t_tbl_rsp   i_rsp,
    output t_result         o_res
);

    t_state            r_state,   n_state;
    t_scan_mode        r_mode,    n_mode;
    t_status           r_status,  n_status;
    logic [PRIO_W-1:0] r_req,     n_req;
    logic [SLOT_W-1:0] r_running, n_running;
    logic [CNT_W-1:0]  r_live,    n_live;
    logic              r_started, n_started;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic              r_found,   n_found;
    logic [PRIO_W-1:0] r_best,    n_best;
    logic [SLOT_W-1:0] r_hit,     n_hit;
    logic [PRIO_W-1:0] r_prev,    n_prev;
    logic              r_prev_set, n_prev_set;
    logic [SLOT_W-1:0] eval_idx;

    // State and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= '0;
            r_live     <= '0;
            r_started  <= 1'b0;
            r_cnt      <= '0;
            r_prev_set <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_running  <= n_running;
            r_live     <= n_live;
            r_started  <= n_started;
            r_cnt      <= n_cnt;
            r_prev_set <= n_prev_set;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_req    <= n_req;
        r_found  <= n_found;
        r_best   <= n_best;
        r_hit    <= n_hit;
        r_prev   <= n_prev;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign eval_idx = SLOT_W'(r_cnt - 1'b1);

    // Next state, table accesses and result.
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_status   = r_status;
        n_req      = r_req;
        n_running  = r_running;
        n_live     = r_live;
        n_started  = r_started;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_best     = r_best;
        n_hit      = r_hit;
        n_prev     = r_prev;
        n_prev_set = r_prev_set;

        o_req.rd_addr  = r_running;
        o_req.wr_addr  = r_running;
        o_req.st_we    = 1'b0;
        o_req.st_wdata = ST_FREE;
        o_req.pr_we    = 1'b0;
        o_req.pr_wdata = '0;

        o_res.valid     = 1'b0;
        o_res.status    = r_status;
        o_res.slot      = r_running;
        o_res.cur_prio  = i_rsp.prio;
        o_res.prev_prio = r_prev_set ? r_prev : i_rsp.prio;

        unique case (r_state)
            S_IDLE: begin
                // The read of the running slot issued here serves yield and set priority.
                if (i_start) begin
                    n_req      = clamp_prio(i_priority_req);
                    n_status   = STS_OK;
                    n_prev_set = 1'b0;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_hit      = '0;
                    n_mode     = MODE_SCHED;
                    unique case (t_cmd'(i_command))
                        CMD_CREATE: begin
                            n_mode  = MODE_CREATE;
                            n_state = S_SCAN;
                        end
                        CMD_YIELD:    n_state = S_YLD_WR;
                        CMD_EXIT:     n_state = S_EXIT_WR;
                        CMD_SET_PRIO: n_state = S_SP_WR;
                        CMD_START: begin
                            if (r_started) begin
                                n_status = STS_STARTED;
                                n_state  = S_FIN;
                            end else begin
                                n_started = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        default:      n_state = S_FIN;
                    endcase
                end
            end

            S_YLD_WR: begin
                // A free running slot stays free.
                if (i_rsp.st != ST_FREE) begin
                    o_req.st_we    = 1'b1;
                    o_req.st_wdata = ST_RUNNABLE;
                end
                n_state = S_SCAN;
            end

            S_EXIT_WR: begin
                o_req.st_we    = 1'b1;
                o_req.st_wdata = ST_FREE;
                o_req.pr_we    = 1'b1;
                o_req.pr_wdata = '0;
                n_live         = (r_live != '0) ? r_live - 1'b1 : '0;
                if (n_live == '0) begin
                    n_status = STS_ALL_EXITED;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_SP_WR: begin
                n_prev         = i_rsp.prio;
                n_prev_set     = 1'b1;
                o_req.pr_we    = 1'b1;
                o_req.pr_wdata = r_req;
                n_state        = S_FIN;
            end

            S_SCAN: begin
                // Issue one read per cycle and judge the slot read the cycle before.
                o_req.rd_addr = r_cnt[SLOT_W-1:0];
                if (r_cnt != '0) begin
                    if (r_mode == MODE_CREATE) begin
                        if (!r_found && i_rsp.st == ST_FREE) begin
                            n_found = 1'b1;
                            n_hit   = eval_idx;
                        end
                    end else begin
                        if (i_rsp.st == ST_RUNNABLE && (!r_found || i_rsp.prio > r_best)) begin
                            n_found = 1'b1;
                            n_best  = i_rsp.prio;
                            n_hit   = eval_idx;
                        end
                    end
                end
                if (r_cnt == CNT_W'(SLOT_COUNT)) begin
                    n_state = (r_mode == MODE_CREATE) ? S_CREATE_WR : S_SCHED_WR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_CREATE_WR: begin
                o_req.wr_addr  = r_hit;
                o_req.st_wdata = ST_RUNNABLE;
                o_req.pr_wdata = r_req;
                if (r_found) begin
                    o_req.st_we = 1'b1;
                    o_req.pr_we = 1'b1;
                    n_live      = r_live + 1'b1;
                end else begin
                    n_status = STS_FULL;
                end
                n_state = S_FIN;
            end

            S_SCHED_WR: begin
                // With nothing runnable the pick stays at slot zero.
                o_req.wr_addr  = r_hit;
                o_req.st_we    = 1'b1;
                o_req.st_wdata = ST_RUNNING;
                n_running      = r_hit;
                n_state        = S_FIN;
            end

            S_FIN: begin
                // Read back the running slot's priority after all writes.
                n_state = S_OUT;
            end

            S_OUT: begin
                o_res.valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // An accepted item always makes the controller busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    // The live count never exceeds the number of slots.
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOT_COUNT))
        else $error("live count out of range");

    // The scan counter stops at the slot count.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOT_COUNT))
        else $error("scan counter overran the table");

    // Scheduling moves the running slot to the pick.
    a_sched_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHED_WR) |=> (r_running == $past(r_hit)))
        else $error("running slot does not follow the scheduler pick");

endmodule

`default_nettype wire

@@ sv/thread_priority_scheduler_top.sv @@
// Static-priority thread slot scheduler.
// Command channel: an item (i_command, i_priority_req) is taken at a rising
// edge where start is high and busy is low. busy stays high while the item
// is worked on; the block handles one item at a time.
// Result channel: o_done is high for exactly one cycle, in the cycle in which
// busy falls, with o_status, o_current_slot, o_current_priority and
// o_previous_priority valid in that cycle. The receiver cannot stall; a new
// start may be given in that same cycle.
// Set priority, start when already started, exit of the last thread and
// unknown commands skip the slot scan; create and the first start scan the
// table; yield and exit with threads left write the running slot, then scan.
// The next item can be taken at the edge that ends the o_done cycle. The
// scan reads the slot table one slot per cycle, with registered read data.
// Reset (i_rst_n low, synchronous) frees every slot, clears all priorities,
// the live count and the started flag, and sets the running slot to zero.
// No clearing pass is needed: per-slot written flags mask unwritten entries.
`default_nettype none

module thread_priority_scheduler_top
    import tps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_command,
    input  wire logic [1:0] i_priority_req,
    output logic            busy,
    output logic            o_done,
    output logic [1:0]      o_status,
    output logic [1:0]      o_current_slot,
    output logic [1:0]      o_current_priority,
    output logic [1:0]      o_previous_priority
);

    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;
    t_result  res;

    tps_slot_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    tps_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .o_busy         (busy),
        .o_req          (tbl_req),
        .i_rsp          (tbl_rsp),
        .o_res          (res)
    );

    // Output register: result fields and the one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            o_status            <= res.status;
            o_current_slot      <= 2'(res.slot);
            o_current_priority  <= 2'(res.cur_prio);
            o_previous_priority <= 2'(res.prev_prio);
        end
    end

    // A result strobe is never held high: each o_done is followed by a low o_done.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire
